// ===== hdl/rlm_pkg.sv =====
// Shared types and constants of the block RMS level meter.
// No dependencies; rlm_front, rlm_back and rms_level_meter refer to this package.
package rlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FLOOR_W  = 15;
    localparam int CEIL_W   = 16;
    localparam int LEVEL_W  = 7;
    localparam int SQ_W     = 31;   // largest square is 2^30
    localparam int ROOT_W   = 16;   // floor root of a mean square up to 2^30
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int PROD_W   = 23;   // (rms - floor) * 100 fits here
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 15'd50;
    localparam logic [CEIL_W-1:0]  CEIL_RESET  = 16'd4000;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOUD_CEILING = 1'd1;

    typedef struct packed {
        logic [FLOOR_W-1:0] noise_floor;
        logic [CEIL_W-1:0]  loud_ceiling;
    } t_cfg;

endpackage

// ===== hdl/rlm_queue.sv =====
// Small first-in first-out queue built from flip-flops.
// Depends on nothing; used for the job queue and the result queue of the meter.
module rlm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/rlm_front.sv =====
// Front end of the meter: squares samples, accumulates the open block and
// hands each closed block to the job queue. Depends on rlm_pkg.
module rlm_front #(
    parameter int MAX_BLOCK_SAMPLES = 256,
    parameter int CNT_W = 9,
    parameter int SUM_W = 39
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_last_in_block,
    input  logic                              i_empty_block,
    output logic                              o_job_push,
    output logic [SUM_W+CNT_W:0]              o_job,
    input  logic                              i_job_full
);
    logic                        r_s1_valid, n_s1_valid;
    logic [rlm_pkg::SQ_W-1:0]    r_s1_sq;
    logic                        r_s1_last;
    logic                        r_s1_empty;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [CNT_W-1:0]            r_total, n_total;

    logic signed [2*rlm_pkg::SAMPLE_W-1:0] sq_full;
    logic [SUM_W-1:0]            sum_add;
    logic [CNT_W-1:0]            cnt_add;
    logic                        s1_close;
    logic                        s1_adv;
    logic                        accept;

    assign sq_full  = i_sample * i_sample;
    assign sum_add  = r_sum + SUM_W'(r_s1_sq);
    assign cnt_add  = r_total + 1'b1;
    assign s1_close = r_s1_empty || r_s1_last || (cnt_add == CNT_W'(MAX_BLOCK_SAMPLES));
    // Hold the squared word while a closing block waits for queue room.
    assign s1_adv   = r_s1_valid && !(s1_close && i_job_full);
    assign o_full   = r_s1_valid && !s1_adv;
    assign accept   = i_push && !o_full;

    assign o_job_push = s1_adv && s1_close;
    assign o_job      = {r_s1_empty, cnt_add, sum_add};

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_sum      = r_sum;
        n_total    = r_total;
        if (s1_adv) begin
            n_s1_valid = 1'b0;
            if (s1_close) begin
                n_sum   = '0;
                n_total = '0;
            end else begin
                n_sum   = sum_add;
                n_total = cnt_add;
            end
        end
        if (accept) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_sum      <= '0;
            r_total    <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_sum      <= n_sum;
            r_total    <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sq    <= sq_full[rlm_pkg::SQ_W-1:0];
            r_s1_last  <= i_last_in_block;
            r_s1_empty <= i_empty_block;
        end
    end

endmodule

// ===== hdl/rlm_back.sv =====
// Back end of the meter: takes one closed block at a time and works out its
// level with a shared shift-subtract divider and a digit-by-digit square root.
// Depends on rlm_pkg.
module rlm_back #(
    parameter int CNT_W = 9,
    parameter int SUM_W = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlm_pkg::t_cfg                 i_cfg,
    input  logic                          i_job_empty,
    output logic                          o_job_pop,
    input  logic [SUM_W+CNT_W:0]          i_job,
    output logic                          o_res_push,
    input  logic                          i_res_full,
    output logic [rlm_pkg::LEVEL_W-1:0]   o_level
);
    localparam int DV_W   = (CNT_W > rlm_pkg::CEIL_W) ? CNT_W : rlm_pkg::CEIL_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int SREM_W = rlm_pkg::ROOT_W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_MAP  = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [STEP_W-1:0]             r_steps, n_steps;
    logic [SUM_W-1:0]              r_quo, n_quo;
    logic [DV_W-1:0]               r_rem, n_rem;
    logic [DV_W-1:0]               r_dvs, n_dvs;
    logic [rlm_pkg::RAD_W-1:0]     r_rad, n_rad;
    logic [SREM_W-1:0]             r_srem, n_srem;
    logic [rlm_pkg::ROOT_W-1:0]    r_root, n_root;
    logic [rlm_pkg::LEVEL_W-1:0]   r_level, n_level;

    logic [SUM_W-1:0]              j_sum;
    logic [CNT_W-1:0]              j_cnt;
    logic                          j_empty;
    logic                          range_ok;
    logic [rlm_pkg::CEIL_W-1:0]    floor_x;
    logic [rlm_pkg::CEIL_W-1:0]    den;
    logic [rlm_pkg::CEIL_W-1:0]    diff;
    logic [rlm_pkg::PROD_W-1:0]    prod;
    logic [DV_W:0]                 rem_sh;
    logic                          dge;
    logic [DV_W:0]                 rem_nx;
    logic [SUM_W-1:0]              quo_nx;
    logic [SREM_W:0]               s_sh;
    logic [SREM_W:0]               trial;
    logic                          sge;
    logic [SREM_W:0]               s_rem_nx;
    logic [rlm_pkg::ROOT_W-1:0]    root_nx;
    logic [rlm_pkg::LEVEL_W-1:0]   lvl_nx;

    assign j_sum    = i_job[SUM_W-1:0];
    assign j_cnt    = i_job[SUM_W +: CNT_W];
    assign j_empty  = i_job[SUM_W+CNT_W];
    assign floor_x  = {1'b0, i_cfg.noise_floor};
    assign range_ok = i_cfg.loud_ceiling > floor_x;
    assign den      = i_cfg.loud_ceiling - floor_x;
    assign diff     = r_root - floor_x;
    assign prod     = rlm_pkg::PROD_W'(diff) * rlm_pkg::PROD_W'(rlm_pkg::LEVEL_MAX);

    // One restoring division step: one quotient bit a cycle.
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign dge    = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = dge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    assign quo_nx = {r_quo[SUM_W-2:0], dge};
    assign lvl_nx = (quo_nx > SUM_W'(rlm_pkg::LEVEL_MAX)) ? rlm_pkg::LEVEL_MAX
                                                          : quo_nx[rlm_pkg::LEVEL_W-1:0];

    // One square root step: two radicand bits in, one root bit out.
    assign s_sh     = {r_srem[SREM_W-2:0], r_rad[rlm_pkg::RAD_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign sge      = s_sh >= trial;
    assign s_rem_nx = sge ? (s_sh - trial) : s_sh;
    assign root_nx  = {r_root[rlm_pkg::ROOT_W-2:0], sge};

    assign o_level = r_level;

    always_comb begin
        n_state    = r_state;
        n_steps    = r_steps;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_rad      = r_rad;
        n_srem     = r_srem;
        n_root     = r_root;
        n_level    = r_level;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    if (j_empty || !range_ok) begin
                        n_level = '0;
                        n_state = S_OUT;
                    end else begin
                        n_quo   = j_sum;
                        n_rem   = '0;
                        n_dvs   = DV_W'(j_cnt);
                        n_steps = STEP_W'(SUM_W);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem   = rem_nx[DV_W-1:0];
                n_quo   = quo_nx;
                n_steps = r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    n_rad   = {1'b0, quo_nx[rlm_pkg::SQ_W-1:0]};
                    n_srem  = '0;
                    n_root  = '0;
                    n_steps = STEP_W'(rlm_pkg::ROOT_W);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_rad   = {r_rad[rlm_pkg::RAD_W-3:0], 2'b00};
                n_srem  = s_rem_nx[SREM_W-1:0];
                n_root  = root_nx;
                n_steps = r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (r_root <= floor_x) begin
                    n_level = '0;
                    n_state = S_OUT;
                end else begin
                    n_quo   = SUM_W'(prod);
                    n_rem   = '0;
                    n_dvs   = DV_W'(den);
                    n_steps = STEP_W'(SUM_W);
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                n_rem   = rem_nx[DV_W-1:0];
                n_quo   = quo_nx;
                n_steps = r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    n_level = lvl_nx;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_rad   <= n_rad;
        r_srem  <= n_srem;
        r_root  <= n_root;
        r_level <= n_level;
    end

endmodule

// ===== hdl/rms_level_meter.sv =====
// Top level of the block RMS level meter: configuration registers, front end,
// job queue, back end and result queue. Depends on rlm_pkg, rlm_queue,
// rlm_front and rlm_back.
//
// Input channel: drive a word (sample, last_in_block, empty_block) and raise
// push; the word is taken at an edge with push high and full low. A block
// closes on last_in_block, on empty_block, or by itself at MAX_BLOCK_SAMPLES.
// Result channel: while empty is low, o_level holds the oldest level (0..100);
// pop at an edge with empty low takes it.
// Configuration: write noise_floor (index 0) or loud_ceiling (index 1) through
// i_cfg_valid/o_cfg_ready only while the meter is idle; ready is always high.
// Flow: the front end takes one word every cycle while full is low. Each closed
// block holds the back end through the mean-square divider, the square root,
// the linear map, the level divider and the handoff to the result queue before
// it takes the next block. A root at or below the floor skips the level divider;
// an empty block or a ceiling not above the floor skips all the arithmetic.
// Stalls: results wait in a two-word queue, then the back end holds its level,
// then two closed blocks wait in the job queue; then a closing word holds and
// full rises until the back end frees a slot.
// Reset: clears the open block, both queues and the sequencer; floor 50, ceiling 4000.
module rms_level_meter #(
    parameter int MAX_BLOCK_SAMPLES = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_last_in_block,
    input  logic                                   i_empty_block,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [rlm_pkg::LEVEL_W-1:0]            o_level,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    // Sample count holds MAX_BLOCK_SAMPLES itself; the sum holds that many
    // squares of up to 2^30 each.
    localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W = (rlm_pkg::SQ_W - 1) + CNT_W;
    localparam int JOB_W = SUM_W + CNT_W + 1;

    rlm_pkg::t_cfg r_cfg;

    logic             job_push;
    logic [JOB_W-1:0] job_in;
    logic             job_full;
    logic             job_pop;
    logic             job_empty;
    logic [JOB_W-1:0] job_out;
    logic             res_push;
    logic             res_full;
    logic [rlm_pkg::LEVEL_W-1:0] res_level;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; the write data is masked to each field width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_floor  <= rlm_pkg::FLOOR_RESET;
            r_cfg.loud_ceiling <= rlm_pkg::CEIL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rlm_pkg::CFG_NOISE_FLOOR: begin
                    r_cfg.noise_floor <= i_cfg_data[rlm_pkg::FLOOR_W-1:0];
                end
                rlm_pkg::CFG_LOUD_CEILING: begin
                    r_cfg.loud_ceiling <= i_cfg_data[rlm_pkg::CEIL_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front end: square and accumulate, one word a cycle while full is low.
    rlm_front #(
        .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
        .CNT_W(CNT_W),
        .SUM_W(SUM_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .o_full(full),
        .i_sample(i_sample),
        .i_last_in_block(i_last_in_block),
        .i_empty_block(i_empty_block),
        .o_job_push(job_push),
        .o_job(job_in),
        .i_job_full(job_full)
    );

    // Closed blocks wait here so the front end keeps taking samples.
    rlm_queue #(
        .WIDTH(JOB_W),
        .DEPTH(2)
    ) u_job_q (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(job_push),
        .i_data(job_in),
        .o_full(job_full),
        .i_pop(job_pop),
        .o_empty(job_empty),
        .o_data(job_out)
    );

    // Back end: mean square, root, linear map and clamp.
    rlm_back #(
        .CNT_W(CNT_W),
        .SUM_W(SUM_W)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_job_empty(job_empty),
        .o_job_pop(job_pop),
        .i_job(job_out),
        .o_res_push(res_push),
        .i_res_full(res_full),
        .o_level(res_level)
    );

    // Result queue parts the back end from the receiver.
    rlm_queue #(
        .WIDTH(rlm_pkg::LEVEL_W),
        .DEPTH(2)
    ) u_res_q (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(res_push),
        .i_data(res_level),
        .o_full(res_full),
        .i_pop(pop),
        .o_empty(empty),
        .o_data(o_level)
    );

endmodule
